// File: rtl/tepq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event queue package
// Shared sizes, command and status codes, and the control bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package tepq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int KIND_BITS   = 4;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Fixed port widths
   localparam int TIME_W   = 64;
   localparam int KIND_W   = 4;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int PEND_W   = 5;

   typedef logic [TIME_W-1:0]    time_type;
   typedef logic [KIND_BITS-1:0] kind_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [CMD_W-1:0]     cmd_code_type;
   typedef logic [STATUS_W-1:0]  status_type;

   localparam cmd_code_type CMD_ADVANCE = 3'd0;
   localparam cmd_code_type CMD_ARM     = 3'd1;
   localparam cmd_code_type CMD_ADD     = 3'd2;
   localparam cmd_code_type CMD_REMOVE  = 3'd3;
   localparam cmd_code_type CMD_JUMP    = 3'd4;
   localparam cmd_code_type CMD_CLEAR   = 3'd5;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic latch;        // capture the accepted request
      logic exec;         // run a non-advance command and send its response
      logic adv_add;      // add the cycle count to the running time
      logic check_quiet;  // sync check found nothing to fire: send one response
      logic fire_start;   // sync check found due events: load the fire counters
      logic fire_pop;     // send the head event and pop it
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic cmd_is_adv;
      logic out_free;
      logic fire_due;
      logic fire_last;
   } dp_stat_type;

endpackage
`default_nettype wire

// File: rtl/tepq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event queue controller
// Sequences one request at a time: capture, execute or sync check, fire loop.
// ----------------------------------------------------------------------------
module tepq_ctrl
   import tepq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire dp_stat_type stat_i,
   output dp_cmd_type       cmd_o
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_FIRE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_o.latch = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat_i.cmd_is_adv) begin
               cmd_o.adv_add = 1'b1;
               state_in      = S_CHECK;
            end else if (stat_i.out_free) begin
               cmd_o.exec = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_CHECK: begin
            if (stat_i.fire_due) begin
               cmd_o.fire_start = 1'b1;
               state_in         = S_FIRE;
            end else if (stat_i.out_free) begin
               cmd_o.check_quiet = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_FIRE: begin
            if (stat_i.out_free) begin
               cmd_o.fire_pop = 1'b1;
               if (stat_i.fire_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/tepq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event queue datapath
// Sorted shift-register queue with parallel compares, time and sync registers,
// and the response register.
// ----------------------------------------------------------------------------
module tepq_dp
   import tepq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd_i,
   output dp_stat_type             stat_o,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [TIME_W-1:0]  req_cycles,
   input  wire logic [TIME_W-1:0]  req_sync_delta,
   input  wire logic [TIME_W-1:0]  req_due_time,
   input  wire logic [KIND_W-1:0]  req_event_kind,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_fired,
   output logic [KIND_W-1:0]       rsp_fired_kind,
   output logic [TIME_W-1:0]       rsp_fired_time,
   output logic                    rsp_last,
   output logic [TIME_W-1:0]       rsp_now_time,
   output logic [KIND_W-1:0]       rsp_last_fired_kind,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [PEND_W-1:0]       rsp_pending_count
);

   // Captured request
   cmd_code_type cmd_ff;
   time_type     cycles_ff, delta_ff, due_ff;
   kind_type     kind_ff;

   // Block state
   time_type run_ff, run_in;
   time_type target_ff, target_in;
   logic     armed_ff, armed_in;
   kind_type recent_ff, recent_in;
   cnt_type  occ_ff, occ_in;
   time_type slot_time_ff [QUEUE_DEPTH];
   time_type slot_time_in [QUEUE_DEPTH];
   kind_type slot_kind_ff [QUEUE_DEPTH];
   kind_type slot_kind_in [QUEUE_DEPTH];

   // Fire loop
   cnt_type  remain_ff, remain_in;
   kind_type fin_kind_ff, fin_kind_in;
   cnt_type  fin_cnt_ff, fin_cnt_in;

   // Response register
   logic       rsp_valid_ff;
   logic       rsp_fired_ff, rsp_fired_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   time_type   rsp_time_ff, rsp_time_in;
   logic       rsp_last_ff, rsp_last_in;
   time_type   rsp_now_ff, rsp_now_in;
   kind_type   rsp_rk_ff, rsp_rk_in;
   status_type rsp_status_ff, rsp_status_in;
   cnt_type    rsp_pend_ff, rsp_pend_in;
   logic       emit;

   // Parallel compares
   logic [QUEUE_DEPTH-1:0] slot_vld, ins, match, rm, le, le_edge;
   logic                   reached;
   cnt_type                due_cnt;
   kind_type               edge_kind;
   logic                   out_free;
   logic                   sorted;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_vld[i] = cnt_type'(i) < occ_ff;
         ins[i]      = !slot_vld[i] || (slot_time_ff[i] > due_ff);
         match[i]    = slot_vld[i] && (slot_kind_ff[i] == kind_ff);
         le[i]       = slot_vld[i] && (slot_time_ff[i] <= run_ff);
      end
      rm[0] = match[0];
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         rm[i] = rm[i-1] || match[i];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         le_edge[i] = le[i] && !le[i+1];
      end
      le_edge[QUEUE_DEPTH-1] = le[QUEUE_DEPTH-1];
      edge_kind = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (le_edge[i]) begin
            edge_kind = slot_kind_ff[i];
         end
      end
      sorted = 1'b1;
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         if (slot_vld[i+1] && (slot_time_ff[i] > slot_time_ff[i+1])) begin
            sorted = 1'b0;
         end
      end
   end

   assign reached  = armed_ff && (run_ff >= target_ff);
   assign due_cnt  = cnt_type'($countones(le));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign stat_o.cmd_is_adv = (cmd_ff == CMD_ADVANCE);
   assign stat_o.out_free   = out_free;
   assign stat_o.fire_due   = reached && (due_cnt != '0);
   assign stat_o.fire_last  = (remain_ff == cnt_type'(1));

   always_comb begin
      run_in        = run_ff;
      target_in     = target_ff;
      armed_in      = armed_ff;
      recent_in     = recent_ff;
      occ_in        = occ_ff;
      slot_time_in  = slot_time_ff;
      slot_kind_in  = slot_kind_ff;
      remain_in     = remain_ff;
      fin_kind_in   = fin_kind_ff;
      fin_cnt_in    = fin_cnt_ff;
      emit          = 1'b0;
      rsp_fired_in  = 1'b0;
      rsp_kind_in   = '0;
      rsp_time_in   = '0;
      rsp_last_in   = 1'b1;
      rsp_status_in = ST_OK;

      if (cmd_i.adv_add) begin
         run_in = run_ff + cycles_ff;
      end

      if (cmd_i.check_quiet) begin
         emit = 1'b1;
         if (reached) begin
            armed_in = 1'b0;
         end
      end

      if (cmd_i.fire_start) begin
         armed_in    = 1'b0;
         remain_in   = due_cnt;
         fin_kind_in = edge_kind;
         fin_cnt_in  = occ_ff - due_cnt;
      end

      if (cmd_i.fire_pop) begin
         emit         = 1'b1;
         rsp_fired_in = 1'b1;
         rsp_kind_in  = slot_kind_ff[0];
         rsp_time_in  = slot_time_ff[0];
         rsp_last_in  = (remain_ff == cnt_type'(1));
         recent_in    = slot_kind_ff[0];
         remain_in    = remain_ff - cnt_type'(1);
         occ_in       = occ_ff - cnt_type'(1);
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            slot_time_in[i] = slot_time_ff[i+1];
            slot_kind_in[i] = slot_kind_ff[i+1];
         end
      end

      if (cmd_i.exec) begin
         emit = 1'b1;
         case (cmd_ff)
            CMD_ARM: begin
               target_in = run_ff + delta_ff;
               armed_in  = 1'b1;
            end
            CMD_ADD: begin
               if (occ_ff == cnt_type'(QUEUE_DEPTH)) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  // Keep entries due no later than the new one, open a hole, shift the rest up
                  for (int i = 0; i < QUEUE_DEPTH; i++) begin
                     if (ins[i]) begin
                        if (i == 0) begin
                           slot_time_in[i] = due_ff;
                           slot_kind_in[i] = kind_ff;
                        end else if (!ins[i-1]) begin
                           slot_time_in[i] = due_ff;
                           slot_kind_in[i] = kind_ff;
                        end else begin
                           slot_time_in[i] = slot_time_ff[i-1];
                           slot_kind_in[i] = slot_kind_ff[i-1];
                        end
                     end
                  end
                  occ_in = occ_ff + cnt_type'(1);
               end
            end
            CMD_REMOVE: begin
               // Close the gap at the first entry of this kind
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  if (rm[i]) begin
                     slot_time_in[i] = slot_time_ff[i+1];
                     slot_kind_in[i] = slot_kind_ff[i+1];
                  end
               end
               if (rm[QUEUE_DEPTH-1]) begin
                  occ_in = occ_ff - cnt_type'(1);
               end
            end
            CMD_JUMP: begin
               if (occ_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_fired_in = 1'b1;
                  rsp_kind_in  = slot_kind_ff[0];
                  rsp_time_in  = slot_time_ff[0];
                  run_in       = slot_time_ff[0];
                  recent_in    = slot_kind_ff[0];
                  occ_in       = occ_ff - cnt_type'(1);
                  for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                     slot_time_in[i] = slot_time_ff[i+1];
                     slot_kind_in[i] = slot_kind_ff[i+1];
                  end
               end
            end
            CMD_CLEAR: begin
               run_in = '0;
               occ_in = '0;
            end
            default: begin
            end
         endcase
      end

      // Responses report the state after the whole command
      rsp_now_in  = run_in;
      rsp_rk_in   = recent_in;
      rsp_pend_in = occ_in;
      if (cmd_i.fire_pop) begin
         rsp_rk_in   = fin_kind_ff;
         rsp_pend_in = fin_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         target_ff    <= '0;
         armed_ff     <= 1'b0;
         recent_ff    <= '0;
         occ_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         target_ff <= target_in;
         armed_ff  <= armed_in;
         recent_ff <= recent_in;
         occ_ff    <= occ_in;
         remain_ff <= remain_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.latch) begin
         cmd_ff    <= req_cmd;
         cycles_ff <= req_cycles;
         delta_ff  <= req_sync_delta;
         due_ff    <= req_due_time;
         kind_ff   <= kind_type'(req_event_kind);
      end
      slot_time_ff <= slot_time_in;
      slot_kind_ff <= slot_kind_in;
      fin_kind_ff  <= fin_kind_in;
      fin_cnt_ff   <= fin_cnt_in;
      if (emit) begin
         rsp_fired_ff  <= rsp_fired_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_now_ff    <= rsp_now_in;
         rsp_rk_ff     <= rsp_rk_in;
         rsp_status_ff <= rsp_status_in;
         rsp_pend_ff   <= rsp_pend_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fired           = rsp_fired_ff;
   assign rsp_fired_kind      = KIND_W'(rsp_kind_ff);
   assign rsp_fired_time      = rsp_time_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_now_time        = rsp_now_ff;
   assign rsp_last_fired_kind = KIND_W'(rsp_rk_ff);
   assign rsp_status          = rsp_status_ff;
   assign rsp_pending_count   = PEND_W'(rsp_pend_ff);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cnt_type'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      sorted)
      else $error("queue entries out of time order");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd_i.fire_pop |=> occ_ff == $past(occ_ff) - cnt_type'(1))
      else $error("fire pop did not drop one entry");

   a_fired_due: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fired_ff |-> rsp_time_ff <= rsp_now_ff)
      else $error("fired event later than running time");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("response overwritten while stalled");

endmodule
`default_nettype wire

// File: rtl/timed_event_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event priority queue
// Up to QUEUE_DEPTH pending events sorted by 64-bit due time, with a running
// time, a sync target and fired-event responses.
//
// Usage:
//   Request channel (req_*): one command per request - advance, arm sync, add,
//   remove, jump to next, clear. req_stall is high while a request is being
//   worked on; one request is in the block at a time.
//   Response channel (rsp_*): every request gives one response, except an
//   advance that reaches an armed sync with events due, which gives one
//   response per fired event, earliest first. rsp_last marks the final
//   response of a request. now_time, last_fired_kind, status and
//   pending_count show the state after the whole command in every response.
//   Sequence: a request is accepted and captured, then executed once the
//   response register is free, and its response registered. An advance
//   instead adds the cycle count, then runs a parallel compare of the running
//   time against the sync target and all queue entries, then the pop loop.
//   A new request is taken only after the previous one has finished.
//   The response register decouples the sides: a new request is accepted
//   while the previous response still waits. When rsp_stall is high the
//   response holds and the controller waits before issuing the next one.
//   Reset (synchronous): empties the queue, zeroes time and sync state.
// ----------------------------------------------------------------------------
module timed_event_priority_queue
   import tepq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [CMD_W-1:0]    req_cmd,
   input  wire logic [TIME_W-1:0]   req_cycles,
   input  wire logic [TIME_W-1:0]   req_sync_delta,
   input  wire logic [TIME_W-1:0]   req_due_time,
   input  wire logic [KIND_W-1:0]   req_event_kind,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_fired,
   output logic [KIND_W-1:0]        rsp_fired_kind,
   output logic [TIME_W-1:0]        rsp_fired_time,
   output logic                     rsp_last,
   output logic [TIME_W-1:0]        rsp_now_time,
   output logic [KIND_W-1:0]        rsp_last_fired_kind,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [PEND_W-1:0]        rsp_pending_count
);

   // Command and status bundles between the sequencer and the queue
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // Sequence capture, execute, sync check and the fire loop
   tepq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat_i    (dp_stat),
      .cmd_o     (dp_cmd)
   );

   // Hold the sorted queue, the time registers and the response register
   tepq_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd_i               (dp_cmd),
      .stat_o              (dp_stat),
      .req_cmd             (req_cmd),
      .req_cycles          (req_cycles),
      .req_sync_delta      (req_sync_delta),
      .req_due_time        (req_due_time),
      .req_event_kind      (req_event_kind),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fired           (rsp_fired),
      .rsp_fired_kind      (rsp_fired_kind),
      .rsp_fired_time      (rsp_fired_time),
      .rsp_last            (rsp_last),
      .rsp_now_time        (rsp_now_time),
      .rsp_last_fired_kind (rsp_last_fired_kind),
      .rsp_status          (rsp_status),
      .rsp_pending_count   (rsp_pending_count)
   );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timed event priority queue testbench
// Drives commands on the request channel and tracks a shadow copy of the
// sorted event queue, the running time and the sync state. Each request gives
// the responses it should cause. Every accepted response is checked field by
// field against the oldest awaited one. Sender gaps and receiver stalls vary
// by phase.
// ----------------------------------------------------------------------------
module tb_top;
   import tepq_pkg::*;

   // One response as seen on the rsp_* ports
   typedef struct packed {
      logic              fired;
      kind_type          fired_kind;
      time_type          fired_time;
      logic              last;
      time_type          now_time;
      kind_type          last_fired_kind;
      status_type        status;
      logic [PEND_W-1:0] pending_count;
   } rsp_item_type;

   // Shadow of the event queue: runs each accepted request and holds the
   // responses it should produce until the block sends them.
   class shadow_event_queue_type;
      time_type     run_time;
      time_type     last_event_time;
      time_type     sync_target;
      logic         sync_armed;
      kind_type     recent_kind;
      time_type     slot_time [QUEUE_DEPTH];
      kind_type     slot_kind [QUEUE_DEPTH];
      int           occupancy;
      rsp_item_type awaited[$];
      int           requests;
      int           responses;
      int           fired_events;
      int           full_drops;
      int           empty_jumps;
      int           mismatches;

      function new();
         run_time        = '0;
         last_event_time = '0;
         sync_target     = '0;
         sync_armed      = 1'b0;
         recent_kind     = '0;
         occupancy       = 0;
         requests        = 0;
         responses       = 0;
         fired_events    = 0;
         full_drops      = 0;
         empty_jumps     = 0;
         mismatches      = 0;
      endfunction

      function void pop_head();
         for (int i = 1; i < occupancy; i++) begin
            slot_time[i-1] = slot_time[i];
            slot_kind[i-1] = slot_kind[i];
         end
         if (occupancy > 0) occupancy--;
      endfunction

      function void apply_request(cmd_code_type cmd, time_type cycles, time_type delta,
                                  time_type due, kind_type kind);
         rsp_item_type fires[$];
         rsp_item_type item;
         status_type   st;
         int           pos;
         st   = ST_OK;
         item = '0;
         requests++;
         case (cmd)
            CMD_ADVANCE: begin
               run_time += cycles;
               if (sync_armed && run_time >= sync_target) begin
                  sync_armed = 1'b0;
                  while (occupancy > 0 && slot_time[0] <= run_time) begin
                     last_event_time = slot_time[0];
                     recent_kind     = slot_kind[0];
                     item.fired      = 1'b1;
                     item.fired_kind = slot_kind[0];
                     item.fired_time = slot_time[0];
                     fires = {fires, item};
                     pop_head();
                  end
               end
            end
            CMD_ARM: begin
               sync_target = run_time + delta;
               sync_armed  = 1'b1;
            end
            CMD_ADD: begin
               if (occupancy >= QUEUE_DEPTH) begin
                  st = ST_FULL;
               end else begin
                  // equal times keep arrival order
                  pos = occupancy;
                  for (int i = 0; i < occupancy; i++) begin
                     if (slot_time[i] > due) begin
                        pos = i;
                        break;
                     end
                  end
                  for (int i = occupancy; i > pos; i--) begin
                     slot_time[i] = slot_time[i-1];
                     slot_kind[i] = slot_kind[i-1];
                  end
                  slot_time[pos] = due;
                  slot_kind[pos] = kind;
                  occupancy++;
               end
            end
            CMD_REMOVE: begin
               pos = -1;
               for (int i = 0; i < occupancy; i++) begin
                  if (slot_kind[i] == kind) begin
                     pos = i;
                     break;
                  end
               end
               if (pos >= 0) begin
                  for (int i = pos; i + 1 < occupancy; i++) begin
                     slot_time[i] = slot_time[i+1];
                     slot_kind[i] = slot_kind[i+1];
                  end
                  occupancy--;
               end
            end
            CMD_JUMP: begin
               if (occupancy == 0) begin
                  st = ST_EMPTY;
               end else begin
                  run_time        = slot_time[0];
                  last_event_time = run_time;
                  recent_kind     = slot_kind[0];
                  item.fired      = 1'b1;
                  item.fired_kind = slot_kind[0];
                  item.fired_time = slot_time[0];
                  fires = {fires, item};
                  pop_head();
               end
            end
            CMD_CLEAR: begin
               run_time        = '0;
               last_event_time = '0;
               occupancy       = 0;
            end
            default: ;
         endcase
         if (st == ST_FULL) full_drops++;
         if (st == ST_EMPTY) empty_jumps++;
         fired_events += fires.size();
         if (fires.size() == 0) begin
            item  = '0;
            fires = {fires, item};
         end
         foreach (fires[k]) begin
            fires[k].last            = (k == fires.size() - 1);
            fires[k].now_time        = run_time;
            fires[k].last_fired_kind = recent_kind;
            fires[k].status          = st;
            fires[k].pending_count   = PEND_W'(occupancy);
            awaited = {awaited, fires[k]};
         end
      endfunction

      function void match(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("rsp_%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (awaited.size() == 0) begin
            $error("response with nothing awaited: fired=%0d kind=%0h now=0x%0h",
                   got.fired, got.fired_kind, got.now_time);
            mismatches++;
            return;
         end
         want = awaited[0];
         awaited.delete(0);
         responses++;
         match("fired", 64'(want.fired), 64'(got.fired));
         match("fired_kind", 64'(want.fired_kind), 64'(got.fired_kind));
         match("fired_time", want.fired_time, got.fired_time);
         match("last", 64'(want.last), 64'(got.last));
         match("now_time", want.now_time, got.now_time);
         match("last_fired_kind", 64'(want.last_fired_kind), 64'(got.last_fired_kind));
         match("status", 64'(want.status), 64'(got.status));
         match("pending_count", 64'(want.pending_count), 64'(got.pending_count));
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd        = '0;
   logic [TIME_W-1:0]   req_cycles     = '0;
   logic [TIME_W-1:0]   req_sync_delta = '0;
   logic [TIME_W-1:0]   req_due_time   = '0;
   logic [KIND_W-1:0]   req_event_kind = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic                rsp_fired;
   logic [KIND_W-1:0]   rsp_fired_kind;
   logic [TIME_W-1:0]   rsp_fired_time;
   logic                rsp_last;
   logic [TIME_W-1:0]   rsp_now_time;
   logic [KIND_W-1:0]   rsp_last_fired_kind;
   logic [STATUS_W-1:0] rsp_status;
   logic [PEND_W-1:0]   rsp_pending_count;

   shadow_event_queue_type sb;
   int                     sender_idle_pct = 0;
   int                     rsp_stall_pct   = 0;

   // Due times for the directed fill: ties at 20 and 50, both time extremes
   time_type fill_time [16] = '{
      64'd0, 64'd20, 64'd20, 64'd5, 64'd110, 64'd111, '1, 64'd50,
      64'd50, 64'd50, 64'd3, 64'd200, 64'd1000, 64'h8000_0000_0000_0000,
      64'd7, 64'd20
   };

   timed_event_priority_queue i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_cycles          (req_cycles),
      .req_sync_delta      (req_sync_delta),
      .req_due_time        (req_due_time),
      .req_event_kind      (req_event_kind),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fired           (rsp_fired),
      .rsp_fired_kind      (rsp_fired_kind),
      .rsp_fired_time      (rsp_fired_time),
      .rsp_last            (rsp_last),
      .rsp_now_time        (rsp_now_time),
      .rsp_last_fired_kind (rsp_last_fired_kind),
      .rsp_status          (rsp_status),
      .rsp_pending_count   (rsp_pending_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the response side at the rate of the current phase
   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // Sample responses on the pre-edge values; the block updates them by
   // nonblocking assignment, so this sees exactly what was handed over.
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.fired           = rsp_fired;
         got.fired_kind      = rsp_fired_kind;
         got.fired_time      = rsp_fired_time;
         got.last            = rsp_last;
         got.now_time        = rsp_now_time;
         got.last_fired_kind = rsp_last_fired_kind;
         got.status          = rsp_status;
         got.pending_count   = rsp_pending_count;
         sb.check_response(got);
      end
   end

   function automatic time_type noise64();
      return {$urandom, $urandom};
   endfunction

   // Present one request: arg goes to the time field the command reads, the
   // other time fields carry noise. Return once the block has accepted it.
   task automatic issue(cmd_code_type cmd, time_type arg, kind_type kind);
      // idle the sender at the phase rate
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_cycles     <= (cmd == CMD_ADVANCE) ? arg : noise64();
      req_sync_delta <= (cmd == CMD_ARM) ? arg : noise64();
      req_due_time   <= (cmd == CMD_ADD) ? arg : noise64();
      req_event_kind <= kind;
      // hold the payload until the block takes it
      do @(posedge clock); while (req_stall);
      sb.apply_request(req_cmd, req_cycles, req_sync_delta, req_due_time, req_event_kind);
   endtask

   // Hold the sender until every awaited response has arrived
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   // Main sequence
   initial begin : stimulus
      int stop_at;
      int roll;
      int phase_idle [4];
      int phase_stall [4];
      phase_idle  = '{0, 76, 0, 37};
      phase_stall = '{0, 0, 76, 37};
      sb = new();

      // hold reset, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling. Start on an empty queue.
      issue(CMD_JUMP, '0, 4'd0);                  // jump with nothing queued
      issue(cmd_code_type'(6), noise64(), 4'd6);  // unused code
      issue(CMD_REMOVE, '0, 4'd4);                // remove a kind that is absent
      for (int i = 0; i < 16; i++) issue(CMD_ADD, fill_time[i], kind_type'(i));
      issue(CMD_ADD, 64'd1, 4'd9);                // queue full, add dropped
      issue(CMD_REMOVE, '0, 4'd5);                // remove a queued kind
      issue(CMD_ARM, 64'd100, 4'd0);
      issue(CMD_ADVANCE, 64'd50, 4'd0);           // sync not yet reached
      issue(CMD_ADVANCE, 64'd60, 4'd0);           // reached: burst of fired events
      issue(CMD_JUMP, '0, 4'd15);
      issue(CMD_CLEAR, '0, 4'd0);
      issue(CMD_ARM, 64'd0, 4'd0);
      issue(CMD_ADVANCE, '1, 4'd0);               // reached with nothing due
      issue(CMD_ADVANCE, 64'd5, 4'd0);            // running time wraps
      drain_responses();

      // Random part: four phases of at least 28 requests each, with their own idle and stall rates
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = phase_idle[ph];
         rsp_stall_pct   = phase_stall[ph];
         stop_at         = sb.requests + 28;
         while (sb.requests < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 65) begin
               // schedule a few events just ahead, then sync and advance on them
               repeat ($urandom_range(1, 5))
                  issue(CMD_ADD, sb.run_time + $urandom_range(0, 300),
                        kind_type'($urandom_range(0, 15)));
               if ($urandom_range(3) == 0 && sb.occupancy > 0)
                  issue(CMD_REMOVE, '0, sb.slot_kind[$urandom_range(0, sb.occupancy - 1)]);
               issue(CMD_ARM, time_type'($urandom_range(0, 200)),
                     kind_type'($urandom_range(0, 15)));
               repeat ($urandom_range(1, 3))
                  issue(CMD_ADVANCE, time_type'($urandom_range(0, 150)),
                        kind_type'($urandom_range(0, 15)));
               if ($urandom_range(2) == 0)
                  issue(CMD_JUMP, '0, kind_type'($urandom_range(0, 15)));
            end else if (roll < 72) begin
               issue(CMD_CLEAR, '0, kind_type'($urandom_range(0, 15)));
            end else begin
               // noise: any code, full-range values
               issue(cmd_code_type'($urandom_range(0, 7)), noise64(),
                     kind_type'($urandom_range(0, 15)));
            end
         end
         // pause the sender until the block has answered everything
         drain_responses();
      end

      // let any trailing activity settle
      repeat (20) @(posedge clock);
      $display("Covered %0d requests, %0d responses, %0d fired events.",
               sb.requests, sb.responses, sb.fired_events);
      $display("Adds dropped on full queue: %0d, jumps on empty queue: %0d.",
               sb.full_drops, sb.empty_jumps);
      if (sb.mismatches == 0) begin
         $display("** timed_event_priority_queue: PASSED **");
      end else begin
         $display("** timed_event_priority_queue: FAILED **");
      end
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #4_000_000;
      $display("** timed_event_priority_queue: FAILED **");
      $finish;
   end

endmodule

// File: timed_event_priority_queue.f
rtl/tepq_pkg.sv
rtl/tepq_ctrl.sv
rtl/tepq_dp.sv
rtl/timed_event_priority_queue.sv
tb/sv/tb_top.sv
